FILE: sv/assert_macros.svh
// assertion macros shared by the sorter rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed: condition");
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, cond)
`define ASSERT_SAME(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: sv/hsd_pkg.sv
// types and constants of the descending sorter
`default_nettype none
package hsd_pkg;
  localparam int CAPACITY = 64;
  localparam int DATA_W = 32;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef logic signed [DATA_W-1:0] word_t;
  typedef logic [CNT_W-1:0] count_t;

  typedef struct packed {
    word_t value;
    logic  last;
  } hsd_item_t;

  typedef struct packed {
    word_t sorted_value;
    logic  final_res;
    logic  overflowed;
  } hsd_res_t;

  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } hsd_state_t;

  typedef struct packed {
    logic load;
    logic shift;
  } hsd_cell_ctrl_t;

  typedef struct packed {
    logic   busy;
    logic   emit;
    logic   last_one;
    logic   dropped;
    count_t count;
  } hsd_stat_t;
endpackage
`default_nettype wire

FILE: sv/hsd_cell.sv
// one cell of the sorted row: insert from the left, shift toward the head
`default_nettype none
module hsd_cell
  import hsd_pkg::*;
(
  input  wire logic           clk,
  input  wire hsd_cell_ctrl_t ctrl,
  input  wire word_t          new_value,
  input  wire logic           occupied,
  input  wire logic           left_take,
  input  wire word_t          left_value,
  input  wire word_t          right_value,
  output logic                take,
  output word_t               value
);
  word_t value_next;

  assign take = !occupied || (new_value > value);

  always_comb begin
    value_next = value;
    if (ctrl.load) begin
      if (left_take) begin
        value_next = left_value;
      end else if (take) begin
        value_next = new_value;
      end
    end else if (ctrl.shift) begin
      value_next = right_value;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end
endmodule
`default_nettype wire

FILE: sv/hsd_ctrl.sv
// load and emit sequencing, element count and drop flag
`default_nettype none
module hsd_ctrl
  import hsd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  input  wire logic      last,
  output hsd_cell_ctrl_t cell_ctrl,
  output hsd_stat_t      stat
);
  hsd_state_t state, state_next;
  count_t     count, count_next;
  count_t     remain, remain_next;
  logic       dropped, dropped_next;
  logic       has_room;

  assign has_room = count < CNT_W'(CAPACITY);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_LOAD;
      count   <= '0;
      remain  <= '0;
      dropped <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      remain  <= remain_next;
      dropped <= dropped_next;
    end
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    remain_next     = remain;
    dropped_next    = dropped;
    cell_ctrl.load  = 1'b0;
    cell_ctrl.shift = 1'b0;
    stat.busy       = 1'b0;
    stat.emit       = 1'b0;
    stat.last_one   = 1'b0;
    case (state)
      ST_LOAD: begin
        if (start) begin
          if (has_room) begin
            cell_ctrl.load = 1'b1;
            count_next     = count + 1'b1;
          end else begin
            dropped_next = 1'b1;
          end
          if (last) begin
            state_next  = ST_EMIT;
            remain_next = has_room ? count + 1'b1 : count;
          end
        end
      end
      ST_EMIT: begin
        stat.busy       = 1'b1;
        stat.emit       = 1'b1;
        cell_ctrl.shift = 1'b1;
        stat.last_one   = remain == CNT_W'(1);
        remain_next     = remain - 1'b1;
        if (remain == CNT_W'(1)) begin
          state_next   = ST_LOAD;
          count_next   = '0;
          dropped_next = 1'b0;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
    stat.dropped = dropped;
    stat.count   = count;
  end
endmodule
`default_nettype wire

FILE: sv/heap_sort_descending_core.sv
// descending sorter built from a row of compare-insert cells
//
//  channel  | handshake            | payload
//  ---------+----------------------+----------------------------------------
//  input    | start, busy          | item  (value, last)
//  result   | res_valid (strobe)   | res   (sorted_value, final_res, overflowed)
//
// loading takes an item whenever start is high; each cell compares the new value
// in parallel and the row stays sorted, largest at the head
// after the item with last, busy is high while the stored items are shifted out of
// the head cell, one result per cycle
// synchronous reset clears control only; cell contents are not reset
// results cannot be stalled; start is ignored while busy
`default_nettype none
`include "assert_macros.svh"
module heap_sort_descending_core
  import hsd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  output logic           busy,
  input  wire hsd_item_t item,
  output logic           res_valid,
  output hsd_res_t       res
);
  hsd_cell_ctrl_t      cell_ctrl;
  hsd_stat_t           stat;
  word_t               cell_value [CAPACITY];
  word_t               left_value [CAPACITY];
  word_t               right_value [CAPACITY];
  logic [CAPACITY-1:0] cell_take;
  logic [CAPACITY-1:0] left_take;
  logic [CAPACITY-1:0] occupied;

  hsd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .last      (item.last),
    .cell_ctrl (cell_ctrl),
    .stat      (stat)
  );

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign left_take[g]  = 1'b0;
      assign left_value[g] = cell_value[g];
    end else begin : g_body
      assign left_take[g]  = cell_take[g-1];
      assign left_value[g] = cell_value[g-1];
    end
    if (g == CAPACITY - 1) begin : g_tail
      assign right_value[g] = cell_value[g];
    end else begin : g_inner
      assign right_value[g] = cell_value[g+1];
    end
    assign occupied[g] = stat.count > CNT_W'(g);

    hsd_cell u_cell (
      .clk         (clk),
      .ctrl        (cell_ctrl),
      .new_value   (item.value),
      .occupied    (occupied[g]),
      .left_take   (left_take[g]),
      .left_value  (left_value[g]),
      .right_value (right_value[g]),
      .take        (cell_take[g]),
      .value       (cell_value[g])
    );
  end

  assign busy             = stat.busy;
  assign res_valid        = stat.emit;
  assign res.sorted_value = cell_value[0];
  assign res.final_res    = stat.last_one;
  assign res.overflowed   = stat.dropped;

  `ASSERT_SAME(a_strobe_busy, clk, rst, res_valid, busy)
  `ASSERT_ALWAYS(a_count_range, clk, rst, stat.count <= CNT_W'(CAPACITY))
  `ASSERT_NEXT(a_final_idle, clk, rst, res_valid && res.final_res, !busy)
  `ASSERT_NEXT(a_last_emits, clk, rst, start && !busy && item.last, res_valid)
endmodule
`default_nettype wire
